@@ rtl/core/psev_pkg.sv @@
// Shared types and constants for the postfix stack evaluator.
// No dependencies; every other file of the block uses this package, except psev_ram.
`default_nettype none

package psev_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int VALUE_WIDTH     = 32;
   localparam int DEPTH_WIDTH     = 5;

   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_APPLY = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC,
      ST_REPLY
   } psev_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV,
      ALU_FINISH
   } alu_state_type;

   typedef struct packed {
      op_code_type                    op;
      logic signed [VALUE_WIDTH-1:0]  left;
      logic signed [VALUE_WIDTH-1:0]  right;
   } alu_cmd_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           sat;
      logic                           dz;
   } alu_res_type;

endpackage

`default_nettype wire

@@ rtl/core/psev_req_if.sv @@
// Request channel of the postfix stack evaluator: valid/ready plus one token.
// Depends on psev_pkg for the value width.
`default_nettype none

interface psev_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              req_type;
   logic signed [psev_pkg::VALUE_WIDTH-1:0] operand_value;
   logic [1:0]                              operator_code;

   modport source (output valid, output req_type, output operand_value,
                   output operator_code, input ready);
   modport sink   (input valid, input req_type, input operand_value,
                   input operator_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/psev_rsp_if.sv @@
// Response channel of the postfix stack evaluator: valid/ready plus status.
// Depends on psev_pkg for the value and depth widths.
`default_nettype none

interface psev_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [psev_pkg::VALUE_WIDTH-1:0] top_value;
   logic [psev_pkg::DEPTH_WIDTH-1:0]        stack_depth;
   logic                                    overflow_flag;
   logic                                    divide_by_zero;
   logic                                    saturated_flag;

   modport source (output valid, output top_value, output stack_depth,
                   output overflow_flag, output divide_by_zero,
                   output saturated_flag, input ready);
   modport sink   (input valid, input top_value, input stack_depth,
                   input overflow_flag, input divide_by_zero,
                   input saturated_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/core/postfix_stack_evaluator.sv @@
// Postfix stack evaluator: takes one token per request (push a Q16.16 number,
// apply + - * / to the two top entries, or clear the stack) and returns one
// response per request with the new top value, the depth and three flags.
// The block handles one request at a time and lowers req ready while busy.
// A push, a clear or an unused request code passes through the fetch and reply
// states only; an operator also waits in the calc state for the shared
// arithmetic unit, which forms the product one multiplier bit per cycle
// (32 steps) and the quotient one bit per cycle over a dividend widened by
// the FRAC_BITS fraction bits (16 for Q16.16), except that a zero divisor
// skips those steps. Ready comes back in the cycle the response turns valid,
// and the next request can be accepted in that same cycle.
// A response that the sink has not yet taken holds the
// block back only at the end of the following request. Stack entries live in a
// small RAM with a registered read port; the top entry is also kept in a
// register so that an operator needs just one RAM read for its left operand.
`default_nettype none

module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = psev_pkg::FRAC_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   psev_req_if.sink   req_bus,
   psev_rsp_if.source rsp_bus
);
   import psev_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // Sequencer and stack bookkeeping.
   psev_state_type              state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] top_ff, top_in;

   // The request being worked on.
   req_kind_type                kind_ff, kind_in;
   op_code_type                 opc_ff, opc_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                        ovf_ff, ovf_in;
   logic                        dz_ff, dz_in;
   logic                        sat_ff, sat_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_top_ff, rsp_top_in;
   logic [DEPTH_WIDTH-1:0]      rsp_depth_ff, rsp_depth_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        rsp_dz_ff, rsp_dz_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   // Control strobes from the sequencer.
   logic                        accept;
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [VALUE_WIDTH-1:0]      ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [VALUE_WIDTH-1:0]      ram_rdata;
   logic                        rsp_load;
   logic                        alu_start;
   alu_cmd_type                 alu_cmd;
   logic                        alu_done;
   alu_res_type                 alu_res;

   logic                        stack_full;
   logic [AW-1:0]               below_top_addr;

   assign stack_full     = (count_ff >= CW'(STACK_DEPTH));
   // Address of the entry under the top; only meaningful with two or more
   // entries, and also the slot that receives an operator's result then.
   assign below_top_addr = AW'(count_ff - CW'(2));

   psev_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   psev_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .cmd   (alu_cmd),
      .done  (alu_done),
      .res   (alu_res)
   );

   // Operands: the popped top is the right operand and the entry under it
   // the left one; a missing entry reads as zero.
   always_comb begin
      alu_cmd.op    = opc_ff;
      alu_cmd.right = (count_ff != '0) ? top_ff : '0;
      alu_cmd.left  = (count_ff >= CW'(2)) ? $signed(ram_rdata) : '0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (kind_ff == REQ_APPLY) begin
               state_in = ST_CALC;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_CALC: begin
            if (alu_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      accept    = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = value_ff;
      ram_raddr = below_top_addr;
      alu_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            accept = req_bus.valid;
         end
         ST_FETCH: begin
            case (kind_ff)
               REQ_PUSH: begin
                  ram_we = !stack_full;
               end
               REQ_APPLY: begin
                  alu_start = 1'b1;
               end
               default: begin
                  ram_we = 1'b0;
               end
            endcase
         end
         ST_CALC: begin
            // The result lands where the left operand was, or at the bottom
            // when fewer than two entries were there.
            ram_we    = alu_done;
            ram_wdata = alu_res.value;
            ram_waddr = (count_ff >= CW'(2)) ? below_top_addr : '0;
         end
         ST_REPLY: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            accept = 1'b0;
         end
      endcase
   end

   // Stack and request registers.
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      kind_in  = kind_ff;
      opc_in   = opc_ff;
      value_in = value_ff;
      ovf_in   = ovf_ff;
      dz_in    = dz_ff;
      sat_in   = sat_ff;
      if (accept) begin
         kind_in  = req_kind_type'(req_bus.req_type);
         opc_in   = op_code_type'(req_bus.operator_code);
         value_in = req_bus.operand_value;
         ovf_in   = 1'b0;
         dz_in    = 1'b0;
         sat_in   = 1'b0;
      end
      if (state_ff == ST_FETCH) begin
         case (kind_ff)
            REQ_PUSH: begin
               if (stack_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
                  top_in   = value_ff;
               end
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (state_ff == ST_CALC && alu_done) begin
         // Two pops and one push: the depth drops by one, or becomes one
         // when the stack held fewer than two entries.
         count_in = (count_ff >= CW'(2)) ? (count_ff - CW'(1)) : CW'(1);
         top_in   = alu_res.value;
         dz_in    = alu_res.dz;
         sat_in   = alu_res.sat;
      end
   end

   // Response register; it may still be full when the next request starts.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_top_in   = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_top_in   = (count_ff != '0) ? top_ff : '0;
         rsp_depth_in = DEPTH_WIDTH'(count_ff);
         rsp_ovf_in   = ovf_ff;
         rsp_dz_in    = dz_ff;
         rsp_sat_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff       <= top_in;
      kind_ff      <= kind_in;
      opc_ff       <= opc_in;
      value_ff     <= value_in;
      ovf_ff       <= ovf_in;
      dz_ff        <= dz_in;
      sat_ff       <= sat_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_dz_ff    <= rsp_dz_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.top_value      = rsp_top_ff;
   assign rsp_bus.stack_depth    = rsp_depth_ff;
   assign rsp_bus.overflow_flag  = rsp_ovf_ff;
   assign rsp_bus.divide_by_zero = rsp_dz_ff;
   assign rsp_bus.saturated_flag = rsp_sat_ff;

endmodule

`default_nettype wire

@@ rtl/core/psev_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module psev_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/psev_alu.sv @@
// Shared fixed-point arithmetic unit: saturating add and subtract, shift-add
// multiply and restoring divide, all over one shared adder.
// Depends on psev_pkg.
`default_nettype none

module psev_alu #(
   parameter int FRAC_BITS = psev_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire psev_pkg::alu_cmd_type cmd,
   output      logic                  done,
   output      psev_pkg::alu_res_type res
);
   import psev_pkg::*;

   // Dividend width: the left magnitude shifted up by the fraction bits.
   localparam int DW        = VALUE_WIDTH + FRAC_BITS;
   localparam int MUL_SHIFT = DW - VALUE_WIDTH;
   localparam int IW        = $clog2(DW);

   alu_state_type           state_ff, state_in;
   logic [IW-1:0]           iter_ff, iter_in;
   logic [32:0]             hi_ff, hi_in;
   logic [DW-1:0]           lo_ff, lo_in;
   logic [31:0]             mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    is_mul_ff, is_mul_in;
   logic                    done_ff, done_in;
   alu_res_type             res_ff, res_in;

   logic [33:0]             add_a, add_b, add_sum;
   logic                    add_sub;
   logic [31:0]             mag_left, mag_right;
   logic [32:0]             div_trial;
   logic [63:0]             product, qmag;
   logic [63:0]             frac_mask;
   logic                    neg_eff;

   assign mag_left  = cmd.left[31]  ? 32'(-cmd.left)  : 32'(cmd.left);
   assign mag_right = cmd.right[31] ? 32'(-cmd.right) : 32'(cmd.right);
   assign div_trial = {hi_ff[31:0], lo_ff[DW-1]};
   assign product   = {hi_ff[31:0], lo_ff[DW-1 -: 32]};
   assign frac_mask = (64'd1 << FRAC_BITS) - 64'd1;

   // The one adder of the unit; its operands depend on the phase.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         ALU_IDLE: begin
            add_a   = {{2{cmd.left[31]}}, cmd.left};
            add_b   = {{2{cmd.right[31]}}, cmd.right};
            add_sub = (cmd.op == OP_SUB);
         end
         ALU_MUL: begin
            add_a = {1'b0, hi_ff};
            add_b = {2'b00, mag_ff};
         end
         ALU_DIV: begin
            add_a   = {1'b0, div_trial};
            add_b   = {2'b00, mag_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_a = '0;
         end
      endcase
      add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ALU_IDLE: begin
            if (start && cmd.op == OP_MUL) begin
               state_in = ALU_MUL;
            end else if (start && cmd.op == OP_DIV && cmd.right != '0) begin
               state_in = ALU_DIV;
            end
         end
         ALU_MUL: begin
            if (iter_ff == IW'(VALUE_WIDTH - 1)) begin
               state_in = ALU_FINISH;
            end
         end
         ALU_DIV: begin
            if (iter_ff == IW'(DW - 1)) begin
               state_in = ALU_FINISH;
            end
         end
         ALU_FINISH: begin
            state_in = ALU_IDLE;
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   // Datapath updates.
   always_comb begin
      iter_in   = iter_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      is_mul_in = is_mul_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      qmag      = '0;
      neg_eff   = 1'b0;
      case (state_ff)
         ALU_IDLE: begin
            iter_in = '0;
            hi_in   = '0;
            neg_in  = cmd.left[31] ^ cmd.right[31];
            if (start) begin
               case (cmd.op)
                  OP_ADD, OP_SUB: begin
                     res_in.dz  = 1'b0;
                     res_in.sat = 1'b0;
                     res_in.value = add_sum[31:0];
                     if (!add_sum[32] && add_sum[31]) begin
                        res_in.value = VAL_MAX;
                        res_in.sat   = 1'b1;
                     end else if (add_sum[32] && !add_sum[31]) begin
                        res_in.value = VAL_MIN;
                        res_in.sat   = 1'b1;
                     end
                     done_in = 1'b1;
                  end
                  OP_MUL: begin
                     is_mul_in = 1'b1;
                     mag_in    = mag_left;
                     lo_in     = DW'(mag_right) << MUL_SHIFT;
                  end
                  OP_DIV: begin
                     is_mul_in = 1'b0;
                     mag_in    = mag_right;
                     lo_in     = DW'(mag_left) << FRAC_BITS;
                     if (cmd.right == '0) begin
                        res_in.value = cmd.left[31] ? VAL_MIN : VAL_MAX;
                        res_in.sat   = 1'b1;
                        res_in.dz    = 1'b1;
                        done_in      = 1'b1;
                     end
                  end
                  default: begin
                     done_in = 1'b0;
                  end
               endcase
            end
         end
         ALU_MUL: begin
            // Add the multiplicand when the current multiplier bit is set,
            // then shift the double-width product right by one.
            if (lo_ff[MUL_SHIFT]) begin
               hi_in = {1'b0, add_sum[32:1]};
               lo_in = {add_sum[0], lo_ff[DW-1:1]};
            end else begin
               hi_in = {1'b0, hi_ff[32:1]};
               lo_in = {hi_ff[0], lo_ff[DW-1:1]};
            end
            iter_in = iter_ff + IW'(1);
         end
         ALU_DIV: begin
            // One quotient bit per cycle: keep the trial difference when it
            // does not borrow.
            if (!add_sum[33]) begin
               hi_in = add_sum[32:0];
               lo_in = {lo_ff[DW-2:0], 1'b1};
            end else begin
               hi_in = div_trial;
               lo_in = {lo_ff[DW-2:0], 1'b0};
            end
            iter_in = iter_ff + IW'(1);
         end
         ALU_FINISH: begin
            if (is_mul_ff) begin
               // Floor of a negative product: round the magnitude up.
               qmag = (product >> FRAC_BITS)
                    + 64'(neg_ff && ((product & frac_mask) != '0));
            end else begin
               qmag = 64'(lo_ff);
            end
            neg_eff    = neg_ff && (qmag != '0);
            res_in.dz  = 1'b0;
            res_in.sat = 1'b0;
            if (neg_eff) begin
               if (qmag > 64'h8000_0000) begin
                  res_in.value = VAL_MIN;
                  res_in.sat   = 1'b1;
               end else begin
                  res_in.value = -qmag[31:0];
               end
            end else begin
               if (qmag > 64'h7FFF_FFFF) begin
                  res_in.value = VAL_MAX;
                  res_in.sat   = 1'b1;
               end else begin
                  res_in.value = qmag[31:0];
               end
            end
            done_in = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff   <= iter_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      is_mul_ff <= is_mul_in;
      res_ff    <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

`default_nettype wire

@@ dv/psev_stack_checker.sv @@
// Checker for the postfix stack evaluator: watches the request and response channels,
// predicts each response with its own copy of the operand stack, and compares every field.
// Depends on psev_pkg and the psev_req_if / psev_rsp_if interfaces.
`timescale 1ns / 1ps

module psev_stack_checker (
   input  logic clock,
   input  logic reset,
   psev_req_if  req_mon,
   psev_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);
   import psev_pkg::*;

   localparam int    STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int    FRAC_BITS   = FRAC_BITS_DEF;
   localparam longint MAX_L      = longint'(VAL_MAX);
   localparam longint MIN_L      = longint'(VAL_MIN);
   localparam int    PRINT_LIMIT = 40;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] top;
      logic [DEPTH_WIDTH-1:0]        depth;
      logic                          ovf;
      logic                          dz;
      logic                          sat;
   } stack_status_type;

   logic signed [VALUE_WIDTH-1:0] stack_image [STACK_DEPTH];
   int                            stack_fill;
   stack_status_type              status_queue [$];
   stack_status_type              want;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      stack_fill     = 0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns: MISMATCH %s", $time, what);
      end
   endtask

   // An empty stack pops as zero.
   function automatic logic signed [VALUE_WIDTH-1:0] pop_value();
      if (stack_fill == 0) begin
         return '0;
      end
      stack_fill--;
      return stack_image[stack_fill];
   endfunction

   function automatic stack_status_type evaluate_token(input logic [1:0] kind,
                                                    input logic signed [VALUE_WIDTH-1:0] operand,
                                                    input logic [1:0] opc);
      stack_status_type              st;
      logic signed [VALUE_WIDTH-1:0] lhs;
      logic signed [VALUE_WIDTH-1:0] rhs;
      longint                        wide;
      st = '0;
      case (kind)
         REQ_PUSH: begin
            if (stack_fill < STACK_DEPTH) begin
               stack_image[stack_fill] = operand;
               stack_fill++;
            end else begin
               st.ovf = 1'b1;
            end
         end
         REQ_APPLY: begin
            rhs = pop_value();
            lhs = pop_value();
            case (opc)
               OP_ADD: wide = longint'(lhs) + longint'(rhs);
               OP_SUB: wide = longint'(lhs) - longint'(rhs);
               // Arithmetic shift of the exact product rounds toward minus infinity.
               OP_MUL: wide = (longint'(lhs) * longint'(rhs)) >>> FRAC_BITS;
               OP_DIV: begin
                  if (rhs == 0) begin
                     // Force out of range so the clamp below picks the rail and flags it.
                     st.dz = 1'b1;
                     wide  = lhs[VALUE_WIDTH-1] ? MIN_L - 1 : MAX_L + 1;
                  end else begin
                     wide = (longint'(lhs) <<< FRAC_BITS) / longint'(rhs);
                  end
               end
               default: wide = 0;
            endcase
            st.sat = (wide > MAX_L) || (wide < MIN_L);
            if (stack_fill < STACK_DEPTH) begin
               stack_image[stack_fill] = st.sat ? ((wide < 0) ? VAL_MIN : VAL_MAX)
                                                : wide[VALUE_WIDTH-1:0];
               stack_fill++;
            end
         end
         REQ_CLEAR: stack_fill = 0;
         default: ;
      endcase
      st.top   = (stack_fill > 0) ? stack_image[stack_fill-1] : '0;
      st.depth = stack_fill[DEPTH_WIDTH-1:0];
      return st;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stack_fill = 0;
         status_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            status_queue.push_back(evaluate_token(req_mon.req_type, req_mon.operand_value,
                                                  req_mon.operator_code));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_queue.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = status_queue.pop_front();
               if (rsp_mon.top_value !== want.top)
                  report_mismatch($sformatf("top_value %h, predicted %h",
                                            rsp_mon.top_value, want.top));
               if (rsp_mon.stack_depth !== want.depth)
                  report_mismatch($sformatf("stack_depth %0d, predicted %0d",
                                            rsp_mon.stack_depth, want.depth));
               if (rsp_mon.overflow_flag !== want.ovf)
                  report_mismatch($sformatf("overflow_flag %b, predicted %b",
                                            rsp_mon.overflow_flag, want.ovf));
               if (rsp_mon.divide_by_zero !== want.dz)
                  report_mismatch($sformatf("divide_by_zero %b, predicted %b",
                                            rsp_mon.divide_by_zero, want.dz));
               if (rsp_mon.saturated_flag !== want.sat)
                  report_mismatch($sformatf("saturated_flag %b, predicted %b",
                                            rsp_mon.saturated_flag, want.sat));
            end
         end
      end
      outstanding = status_queue.size();
   end

endmodule

@@ dv/tb.sv @@
// Top of the postfix stack evaluator testbench: clock, reset, request stimulus and
// response back-pressure, plus the final verdict. Depends on psev_pkg, the channel
// interfaces, postfix_stack_evaluator and psev_stack_checker.
`timescale 1ns / 1ps

module tb;
   import psev_pkg::*;

   localparam int         STACK_DEPTH   = STACK_DEPTH_DEF;
   // The request code that the block does not define; it must leave the stack alone.
   localparam logic [1:0] REQ_UNUSED    = 2'd3;
   localparam int         RANDOM_TOKENS = 1900;
   // The last stretch of the run goes at full rate on both channels.
   localparam int         QUIET_TOKENS  = 300;
   // A divide is the slowest request, so this covers the tail comfortably.
   localparam int         DRAIN_CYCLES  = 80;
   // Worst legal gap between two handshakes is a sender gap, a divide and a receiver
   // stall; the limit is well above that.
   localparam int         STALL_LIMIT   = 2000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;

   psev_req_if req_bus ();
   psev_rsp_if rsp_bus ();

   postfix_stack_evaluator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   psev_stack_checker stack_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Random idling on both channels is enabled until the quiet tail of the run.
   bit idle_on = 1'b1;

   // The stimulus keeps its own idea of the stack depth. It is only used to shape
   // well-formed expressions; all checking happens in the checker.
   int shadow_depth = 0;
   int pushes_left  = 0;
   int tokens_by_kind [4];
   int ops_by_code    [4];
   int overflow_tries = 0;
   int responses_seen = 0;
   int idle_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sends one request. Valid is held high across back-to-back requests, so it is
   // only lowered when a random gap is inserted in front of this one.
   task automatic send_token(input logic [1:0] kind, input logic [31:0] value,
                             input logic [1:0] opc);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.operand_value <= value;
      req_bus.operator_code <= opc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tokens_by_kind[kind]++;
      case (kind)
         REQ_PUSH: begin
            if (shadow_depth < STACK_DEPTH) shadow_depth++;
            else overflow_tries++;
         end
         REQ_APPLY: begin
            ops_by_code[opc]++;
            shadow_depth = (shadow_depth > 1) ? shadow_depth - 1 : 1;
         end
         REQ_CLEAR: shadow_depth = 0;
         default: ;
      endcase
   endtask

   // Operands lean toward the interesting corners: the two rails, zero (which drives
   // the divide-by-zero path), plus or minus one, fully random bit patterns, and
   // modest Q16.16 values that keep products and quotients in range.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h0001_0000;
         4, 5: return $urandom;
         default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      endcase
   endfunction

   // Response back-pressure: random bursts of stalled cycles between runs of
   // ready, and no stalls at all once the quiet tail starts.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // Watchdog: any cycle with a handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) responses_seen++;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int roll;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_PUSH;
      req_bus.operand_value <= '0;
      req_bus.operator_code <= OP_ADD;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The tokens chain so that each result becomes an operand of
      // the next check, which keeps this part short.
      send_token(REQ_CLEAR, 32'h0, OP_ADD);
      // Operator on an empty stack: both operands read as zero.
      send_token(REQ_APPLY, 32'h0, OP_ADD);
      // Operator with a single entry; this is also zero divided by zero.
      send_token(REQ_APPLY, 32'h0, OP_DIV);
      // Positive overflow of an add.
      send_token(REQ_PUSH, VAL_MAX, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_ADD);
      // Product of the two rails clamps negative.
      send_token(REQ_PUSH, VAL_MIN, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_MUL);
      // Negative overflow of a subtract.
      send_token(REQ_PUSH, 32'h1, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_SUB);
      // Zero divisor with a negative dividend.
      send_token(REQ_PUSH, 32'h0, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_DIV);
      // Most negative value divided by minus one clamps positive.
      send_token(REQ_PUSH, 32'hFFFF_0000, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_DIV);
      // One half times minus one lsb must round down to minus one lsb.
      send_token(REQ_PUSH, 32'h0000_8000, OP_ADD);
      send_token(REQ_PUSH, 32'hFFFF_FFFF, OP_ADD);
      send_token(REQ_APPLY, 32'h0, OP_MUL);
      // Fill the stack, push once more onto the full stack, then run an operator
      // at full depth and the unused request code one entry short of full depth.
      while (shadow_depth < STACK_DEPTH) send_token(REQ_PUSH, pick_operand(), OP_ADD);
      send_token(REQ_PUSH, $urandom, OP_ADD);
      send_token(REQ_APPLY, $urandom, OP_SUB);
      send_token(REQ_UNUSED, $urandom, OP_MUL);

      // Random part. Most requests build well-formed expressions: a run of pushes
      // to a random depth (sometimes past the top of the stack) followed by
      // operators down to a single entry. A few percent are noise: clears, the
      // unused code and stray operators at whatever depth the stack happens to be.
      for (int n = 0; n < RANDOM_TOKENS; n++) begin
         if (n == RANDOM_TOKENS - QUIET_TOKENS) idle_on = 1'b0;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_token(REQ_CLEAR, $urandom, 2'($urandom_range(0, 3)));
            pushes_left = 0;
         end else if (roll < 5) begin
            send_token(REQ_UNUSED, $urandom, 2'($urandom_range(0, 3)));
         end else if (roll < 8) begin
            send_token(REQ_APPLY, $urandom, 2'($urandom_range(0, 3)));
         end else begin
            if (pushes_left == 0 && shadow_depth <= 1)
               pushes_left = $urandom_range(1, STACK_DEPTH + 1);
            if (pushes_left > 0) begin
               send_token(REQ_PUSH, pick_operand(), 2'($urandom_range(0, 3)));
               pushes_left--;
            end else begin
               send_token(REQ_APPLY, $urandom, 2'($urandom_range(0, 3)));
            end
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for every predicted response, then give the block time to show any
      // response that should not be there.
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pushes (%0d onto a full stack), %0d clears, %0d unused codes",
               tokens_by_kind[REQ_PUSH], overflow_tries, tokens_by_kind[REQ_CLEAR],
               tokens_by_kind[REQ_UNUSED]);
      $display("Operators add %0d, sub %0d, mul %0d, div %0d; %0d responses checked",
               ops_by_code[OP_ADD], ops_by_code[OP_SUB], ops_by_code[OP_MUL],
               ops_by_code[OP_DIV], responses_seen);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
